// File: hdl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the six-step commutator
// Command codes, register indexes, pulse-width thresholds, result struct and
// the commutation gate table.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // item command codes
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    REG_BASE_PERIOD = 1'b0,
    REG_MIRROR      = 1'b1
  } reg_idx_t;

  localparam logic [15:0] BASE_PERIOD_RST = 16'd2200;

  localparam logic [4:0] WIDTH_MAX    = 5'd20;
  localparam logic [4:0] WIDTH_MID    = 5'd10;
  localparam logic [4:0] STANDBY_LOW  = 5'd9;
  localparam logic [4:0] STANDBY_HIGH = 5'd11;
  localparam logic [7:0] WIDTH_SCALE  = 8'd200;
  localparam int         DROP_BITS    = 11;   // 10 * 200 fits in 11 bits

  localparam logic [2:0] STEP_FIRST = 3'd1;
  localparam logic [2:0] STEP_LAST  = 3'd6;
  localparam logic [2:0] STEP_RST   = 3'd3;

  typedef struct packed {
    logic [5:0] gate_drive;
    logic [2:0] step_index;
    logic       reverse_dir;
    logic       standby;
    logic [4:0] captured_width;
  } res_t;

  // gate pattern per commutation step; step 0 is all off
  function automatic logic [5:0] gate_for_step(input logic [2:0] step);
    logic [5:0] g;
    case (step)
      3'd1:    g = 6'h09;
      3'd2:    g = 6'h21;
      3'd3:    g = 6'h24;
      3'd4:    g = 6'h06;
      3'd5:    g = 6'h12;
      3'd6:    g = 6'h18;
      default: g = 6'h00;
    endcase
    return g;
  endfunction

endpackage

// File: hdl/ssc_core.sv
// ----------------------------------------------------------------------------
// ssc_core: commutation state update
// Holds pulse, timer, step and gate state; computes the next state and the
// result for one accepted item in a single pass.
// ----------------------------------------------------------------------------
module ssc_core #(
  parameter int PERIOD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          cmd,
  input  logic          pulse_level,
  input  logic [15:0]   base_period,
  input  logic          mirror_rotation,
  output ssc_pkg::res_t res
);
  import ssc_pkg::*;

  localparam int CMP_W = (PERIOD_BITS > DROP_BITS) ? PERIOD_BITS : DROP_BITS;

  logic [4:0]             pulse_count_r, pulse_count_nxt;
  logic [4:0]             width_hold_r,  width_hold_nxt;
  logic [PERIOD_BITS-1:0] tick_count_r,  tick_count_nxt;
  logic [PERIOD_BITS-1:0] period_now_r,  period_now_nxt;
  logic [2:0]             step_now_r,    step_now_nxt;
  logic                   dir_rev_r,     dir_rev_nxt;
  logic [5:0]             gates_r,       gates_nxt;

  logic [PERIOD_BITS-1:0] base_m, tick_inc, load_per;
  logic [3:0]             dev;
  logic [DROP_BITS-1:0]   drop;
  logic [CMP_W-1:0]       drop_w, base_w;
  logic                   standby_cur, standby_new, want_rev, upward;

  assign base_m      = PERIOD_BITS'(base_period);
  assign tick_inc    = tick_count_r + 1'b1;
  assign standby_cur = (width_hold_r >= STANDBY_LOW) && (width_hold_r <= STANDBY_HIGH);
  assign standby_new = (width_hold_nxt >= STANDBY_LOW) && (width_hold_nxt <= STANDBY_HIGH);
  assign want_rev    = !(width_hold_r > STANDBY_HIGH);

  // reload value: base minus deviation times scale, floored at zero
  assign dev      = (width_hold_r > WIDTH_MID) ? 4'(width_hold_r - WIDTH_MID)
                                               : 4'(WIDTH_MID - width_hold_r);
  assign drop     = DROP_BITS'(dev) * DROP_BITS'(WIDTH_SCALE);
  assign drop_w   = CMP_W'(drop);
  assign base_w   = CMP_W'(base_m);
  assign load_per = (drop_w >= base_w) ? '0 : PERIOD_BITS'(base_w - drop_w);

  always_comb begin
    pulse_count_nxt = pulse_count_r;
    width_hold_nxt  = width_hold_r;
    tick_count_nxt  = tick_count_r;
    period_now_nxt  = period_now_r;
    step_now_nxt    = step_now_r;
    dir_rev_nxt     = dir_rev_r;
    gates_nxt       = gates_r;
    upward          = 1'b1;
    if (accept) begin
      if (cmd == CMD_SAMPLE) begin
        if (pulse_level && (pulse_count_r < WIDTH_MAX)) begin
          pulse_count_nxt = pulse_count_r + 5'd1;
        end else if (!pulse_level && (pulse_count_r != '0)) begin
          width_hold_nxt  = pulse_count_r;
          pulse_count_nxt = '0;
        end
      end else if (standby_cur) begin
        gates_nxt      = '0;
        tick_count_nxt = '0;
        period_now_nxt = base_m;
      end else begin
        tick_count_nxt = tick_inc;
        if (want_rev != dir_rev_r) begin
          dir_rev_nxt    = want_rev;
          tick_count_nxt = '0;
          period_now_nxt = base_m;
        end
        if (tick_count_nxt >= period_now_nxt) begin
          tick_count_nxt = '0;
          period_now_nxt = load_per;
          upward         = !(dir_rev_nxt ^ mirror_rotation);
          if (upward) begin
            step_now_nxt = ((step_now_r >= STEP_LAST) || (step_now_r == '0))
                           ? STEP_FIRST : step_now_r + 3'd1;
          end else begin
            step_now_nxt = ((step_now_r <= STEP_FIRST) || (step_now_r > STEP_LAST))
                           ? STEP_LAST : step_now_r - 3'd1;
          end
          gates_nxt = gate_for_step(step_now_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r <= '0;
      width_hold_r  <= '0;
      tick_count_r  <= '0;
      period_now_r  <= PERIOD_BITS'(BASE_PERIOD_RST);
      step_now_r    <= STEP_RST;
      dir_rev_r     <= 1'b0;
      gates_r       <= '0;
    end else begin
      pulse_count_r <= pulse_count_nxt;
      width_hold_r  <= width_hold_nxt;
      tick_count_r  <= tick_count_nxt;
      period_now_r  <= period_now_nxt;
      step_now_r    <= step_now_nxt;
      dir_rev_r     <= dir_rev_nxt;
      gates_r       <= gates_nxt;
    end
  end

  // result reflects state after the item
  always_comb begin
    res.gate_drive     = gates_nxt;
    res.step_index     = step_now_nxt;
    res.reverse_dir    = dir_rev_nxt;
    res.standby        = standby_new;
    res.captured_width = width_hold_nxt;
  end

endmodule

// File: hdl/ssc_out_buf.sv
// ----------------------------------------------------------------------------
// ssc_out_buf: result register with skid stage
// Two-entry output buffer; input stall is registered and rises only when
// both entries are held.
// ----------------------------------------------------------------------------
module ssc_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssc_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output ssc_pkg::res_t out_data
);
  import ssc_pkg::*;

  logic head_vld_r, head_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t head_r, skid_r;
  logic pop;

  assign pop       = head_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (pop) begin
        skid_vld_nxt = 1'b0;
      end
    end else begin
      head_vld_nxt = push || (head_vld_r && !pop);
      skid_vld_nxt = push && head_vld_r && !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        head_r <= skid_r;
      end
    end else if (push) begin
      if (!head_vld_r || pop) begin
        head_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

// File: hdl/six_step_commutator_pulse_speed_top.sv
// ----------------------------------------------------------------------------
// six_step_commutator_pulse_speed_top: open-loop six-step BLDC commutator
// Control-pulse driven speed and direction, step timer and gate table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item per transfer. in_cmd selects
//   a pulse sample (in_pulse_level is the control pulse level) or a motor
//   timer tick. Every item yields exactly one result.
//   Result channel (out_valid / out_stall): gate pattern, step, direction,
//   standby flag and last captured pulse width, as they stand after the item.
//   Config channel (cfg_valid / cfg_ready): cfg_index 0 = base period,
//   1 = mirror rotation (bit 0 of cfg_data). cfg_ready is always high; write
//   only while no items are in flight.
//   Throughput: one item per cycle while in_stall is low; each result is
//   registered. The whole update is one pass through a compare, a counter
//   and the gate table between the state registers.
//   Stall: results wait in a two-entry output buffer (result register plus
//   skid). in_stall is registered and goes high only when both are occupied.
//   Reset (rst_n low, synchronous): timers and pulse count cleared, step 3,
//   forward, gates off, base period 2200, mirror off, buffer empty.
// ----------------------------------------------------------------------------
module six_step_commutator_pulse_speed_top #(
  parameter int PERIOD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic        in_pulse_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_gate_drive,
  output logic [2:0]  out_step_index,
  output logic        out_reverse_dir,
  output logic        out_standby,
  output logic [4:0]  out_captured_width,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ssc_pkg::*;

  logic [15:0] base_period_r;
  logic        mirror_r;
  logic        in_xfer;
  logic        buf_full;
  res_t        core_res, buf_res;

  // config registers, written in place
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r <= BASE_PERIOD_RST;
      mirror_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_PERIOD: base_period_r <= cfg_data;
        REG_MIRROR:      mirror_r      <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // transfer in when the skid entry is free
  assign in_stall = buf_full;
  assign in_xfer  = in_valid && !buf_full;

  ssc_core #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_xfer),
    .cmd             (in_cmd),
    .pulse_level     (in_pulse_level),
    .base_period     (base_period_r),
    .mirror_rotation (mirror_r),
    .res             (core_res)
  );

  ssc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (buf_res)
  );

  assign out_gate_drive     = buf_res.gate_drive;
  assign out_step_index     = buf_res.step_index;
  assign out_reverse_dir    = buf_res.reverse_dir;
  assign out_standby        = buf_res.standby;
  assign out_captured_width = buf_res.captured_width;

endmodule

// File: hdl/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks for the six-step commutator
// Result hold under stall and consistency of the reported commutation state.
// ----------------------------------------------------------------------------
module ssc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_gate_drive,
  input logic [2:0] out_step_index,
  input logic       out_standby,
  input logic [4:0] out_captured_width
);
  import ssc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gate_drive)
      && $stable(out_step_index) && $stable(out_captured_width))
    else $error("result changed while stalled");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_step_index >= 3'd1) && (out_step_index <= 3'd6))
    else $error("step index out of range");

  // standby flag follows the captured width; gates clear on the next tick
  a_standby_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_standby == ((out_captured_width >= STANDBY_LOW)
                                  && (out_captured_width <= STANDBY_HIGH)))
    else $error("standby flag does not match captured width");

  a_two_gates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_gate_drive) == 0) || ($countones(out_gate_drive) == 2))
    else $error("gate pattern not a single commutation pair");

endmodule

bind six_step_commutator_pulse_speed_top ssc_checker u_ssc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_gate_drive     (out_gate_drive),
  .out_step_index     (out_step_index),
  .out_standby        (out_standby),
  .out_captured_width (out_captured_width)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the six-step commutator
// Drives sample and tick items through the stall handshake, predicts gate
// pattern, step, direction, standby and captured width for every transfer,
// and compares each result in order. Configuration is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import ssc_pkg::*;

  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 4;     // settle margin once every forecast is matched
  localparam int PHASE_ITEMS    = 250;
  localparam int MAX_REPORTS    = 200;

  typedef struct {
    cmd_t op;
    logic level;
  } pulse_item_t;

  // DUT-facing signals; the driven ones are known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_t        in_cmd = CMD_SAMPLE;
  logic        in_pulse_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_gate_drive;
  logic [2:0]  out_step_index;
  logic        out_reverse_dir;
  logic        out_standby;
  logic [4:0]  out_captured_width;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_BASE_PERIOD;
  logic [15:0] cfg_data = 16'd0;

  // stimulus and expectation stores
  pulse_item_t pulse_items[$];
  res_t        drive_forecast[$];
  int          queued_items = 0;
  int          sent_items = 0;
  int          mismatches = 0;

  // run-mode flags, set from the sequencer with nonblocking writes
  logic        steady_run = 1'b0;   // no idling on either side
  logic        hold_req = 1'b0;     // toggle asks for one long hold-off

  // commutator shadow: configuration and state
  logic [15:0] base_reg;
  logic        mirror_reg;
  logic [4:0]  pulse_cnt;
  logic [4:0]  width_held;
  logic [15:0] tick_cnt;
  logic [15:0] period_cur;
  logic [2:0]  step_cur;
  logic        dir_rev;
  logic [5:0]  gates_cur;

  int          gap_left = 0;
  int          hold_left = 0;
  int          burst_left = 0;
  logic        hold_seen = 1'b0;
  int          idle_cycles = 0;

  six_step_commutator_pulse_speed_top #(
    .PERIOD_BITS(16)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_pulse_level    (in_pulse_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_gate_drive    (out_gate_drive),
    .out_step_index    (out_step_index),
    .out_reverse_dir   (out_reverse_dir),
    .out_standby       (out_standby),
    .out_captured_width(out_captured_width),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Shadow model
  // ------------------------------------------------------------------------

  // low-side/high-side pair per step; anything outside 1..6 is all off
  function automatic logic [5:0] phase_gates(input logic [2:0] s);
    case (s)
      3'd1:    return 6'h09;
      3'd2:    return 6'h21;
      3'd3:    return 6'h24;
      3'd4:    return 6'h06;
      3'd5:    return 6'h12;
      3'd6:    return 6'h18;
      default: return 6'h00;
    endcase
  endfunction

  function automatic logic in_dead_band();
    return width_held >= STANDBY_LOW && width_held <= STANDBY_HIGH;
  endfunction

  task automatic reset_shadow();
    base_reg   = BASE_PERIOD_RST;
    mirror_reg = 1'b0;
    pulse_cnt  = '0;
    width_held = '0;
    tick_cnt   = '0;
    period_cur = BASE_PERIOD_RST;
    step_cur   = STEP_RST;
    dir_rev    = 1'b0;
    gates_cur  = '0;
  endtask

  // one item in, one gate state out
  task automatic commutate_item(input cmd_t op, input logic lvl, output res_t r);
    logic [4:0]  dev;
    logic [15:0] drop;
    logic        want_rev;
    if (op == CMD_SAMPLE) begin
      // count high time, capture on the low level; saturates at the max
      if (lvl && pulse_cnt < WIDTH_MAX) begin
        pulse_cnt = pulse_cnt + 5'd1;
      end else if (!lvl && pulse_cnt != '0) begin
        width_held = pulse_cnt;
        pulse_cnt  = '0;
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;   // wraps at 16 bits
      if (in_dead_band()) begin
        gates_cur  = '0;
        tick_cnt   = '0;
        period_cur = base_reg;
      end else begin
        // zero width (nothing captured yet) falls on the reverse side
        want_rev = (width_held <= STANDBY_HIGH);
        if (want_rev != dir_rev) begin
          dir_rev    = want_rev;
          tick_cnt   = '0;
          period_cur = base_reg;
        end
        if (tick_cnt >= period_cur) begin
          tick_cnt   = '0;
          dev        = (width_held > WIDTH_MID) ? width_held - WIDTH_MID
                                                : WIDTH_MID - width_held;
          drop       = 16'(dev) * 16'(WIDTH_SCALE);
          period_cur = (drop >= base_reg) ? 16'd0 : base_reg - drop;
          if (dir_rev ^ mirror_reg) begin
            step_cur = (step_cur <= STEP_FIRST || step_cur > STEP_LAST)
                       ? STEP_LAST : step_cur - 3'd1;
          end else begin
            step_cur = (step_cur >= STEP_LAST || step_cur == 3'd0)
                       ? STEP_FIRST : step_cur + 3'd1;
          end
          gates_cur = phase_gates(step_cur);
        end
      end
    end
    r.gate_drive     = gates_cur;
    r.step_index     = step_cur;
    r.reverse_dir    = dir_rev;
    r.standby        = in_dead_band();
    r.captured_width = width_held;
  endtask

  // ------------------------------------------------------------------------
  // Driver: pops pending items, holds payload while stalled, inserts random
  // gaps. The shadow model advances on every input transfer and on every
  // config write, both seen at the same edge the DUT sees them.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_item_t it;
    res_t        r;
    if (!rst_n) begin
      reset_shadow();
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BASE_PERIOD) begin
          base_reg = cfg_data;
        end else begin
          mirror_reg = cfg_data[0];
        end
      end
      if (in_valid && !in_stall) begin
        commutate_item(in_cmd, in_pulse_level, r);
        drive_forecast.push_back(r);
        sent_items++;
      end
      // a new item may be presented once the current one has moved
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !steady_run) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pulse_items.size() != 0 && !steady_run &&
                     $urandom_range(0, 15) == 0) begin
          in_valid <= 1'b0;                      // start a random idle burst
          gap_left <= $urandom_range(0, 10);
        end else if (pulse_items.size() != 0) begin
          it = pulse_items.pop_front();
          in_cmd         <= it.op;
          in_pulse_level <= it.level;
          in_valid       <= 1'b1;
          gap_left       <= 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver back-pressure: one long hold on request, else random bursts.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      burst_left <= 0;
      hold_seen  <= hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left != 0 && !steady_run) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (!steady_run && $urandom_range(0, 11) == 0) begin
      burst_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      burst_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest forecast.
  // ------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_forecast.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual gates %0h step %0d",
                   $time, out_gate_drive, out_step_index);
      end else begin
        w = drive_forecast.pop_front();
        check_field("gate_drive", w.gate_drive, out_gate_drive);
        check_field("step_index", w.step_index, out_step_index);
        check_field("reverse_dir", w.reverse_dir, out_reverse_dir);
        check_field("standby", w.standby, out_standby);
        check_field("captured_width", w.captured_width, out_captured_width);
      end
    end
  end

  // Watchdog: no transfer on any channel for too long means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Sequencer helpers
  // ------------------------------------------------------------------------
  task automatic add_item(input cmd_t op, input logic lvl);
    pulse_item_t it;
    it.op    = op;
    it.level = lvl;
    pulse_items.push_back(it);
    queued_items++;
  endtask

  // n high samples, then the falling level that captures them
  task automatic add_pulse(input int n);
    repeat (n) add_item(CMD_SAMPLE, 1'b1);
    add_item(CMD_SAMPLE, 1'b0);
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_item(CMD_TICK, 1'b0);
  endtask

  // sender stops here until every forecast has been matched
  task automatic wait_idle();
    while (sent_items != queued_items || drive_forecast.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed pulse/tick trains so the timer actually commutates;
  // the rest is random noise on both fields.
  task automatic queue_phase_items(input int n);
    int made;
    int w;
    int t;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 3))
          0:       w = $urandom_range(1, 8);     // reverse
          1:       w = $urandom_range(9, 11);    // dead band
          2:       w = $urandom_range(12, 20);   // forward
          default: w = $urandom_range(19, 24);   // saturating count
        endcase
        t = $urandom_range(1, 30);
        add_pulse(w);
        add_ticks(t);
        made += w + 1 + t;
      end else begin
        t = $urandom_range(1, 8);
        repeat (t) add_item(cmd_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made += t;
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] base, input logic mirror, input logic hold);
    wait_idle();
    write_reg(REG_BASE_PERIOD, base);
    write_reg(REG_MIRROR, {15'd0, mirror});
    queue_phase_items(PHASE_ITEMS);
    // the block fills up behind the hold and pushes back on the input
    if (hold) hold_req <= ~hold_req;
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset configuration.
    // No width captured yet: ticks run reverse from the reset step.
    add_ticks(3);
    // low level with nothing counted captures nothing
    add_item(CMD_SAMPLE, 1'b0);
    // lower edge of the dead band, then a tick with all gates off
    add_pulse(9);
    add_ticks(1);
    // leave standby forward; gates stay off until a step is taken
    add_pulse(12);
    add_ticks(1);

    // Random phases across the register range, extremes included.
    run_phase(16'd0, 1'b1, 1'b0);                 // zero period: step per tick
    run_phase(16'hFFFF, 1'b0, 1'b1);              // widest base, long hold-off
    run_phase(16'd1, 1'b0, 1'b0);
    run_phase(16'd450, 1'b1, 1'b0);
    run_phase(16'($urandom_range(0, 1500)), 1'($urandom_range(0, 1)), 1'b0);

    // last stretch with no idling on either side
    wait_idle();
    steady_run <= 1'b1;
    run_phase(16'($urandom_range(100, 700)), 1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && drive_forecast.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: six_step_commutator_pulse_speed_top.f
hdl/ssc_pkg.sv
hdl/ssc_core.sv
hdl/ssc_out_buf.sv
hdl/six_step_commutator_pulse_speed_top.sv
hdl/ssc_checker.sv
tb/tb_top.sv
